>>> design/b64sc_pkg.sv
`default_nettype none

package b64sc_pkg;

	// register map
	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0] REG_DIRECTION = 1'd0;

	// direction codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// padding character
	localparam logic [7:0] PAD_CHAR = 8'h3d;

	// results of one input transfer, first byte at index 0
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            any;
	} result_t;

	// sextet to alphabet character
	function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			c = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

	// alphabet character to sextet, bit 6 set for a character outside the alphabet
	function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'd0;
		if (ch >= 8'h41 && ch <= 8'h5a) begin
			d = ch - 8'h41;
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin
			d = ch - 8'h61 + 8'd26;
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			d = ch - 8'h30 + 8'd52;
		end else if (ch == 8'h2b) begin
			d = 8'd62;
		end else if (ch == 8'h2f) begin
			d = 8'd63;
		end else begin
			d = 8'd64;
		end
		return d[6:0];
	endfunction

endpackage

`default_nettype wire

>>> design/base64_stream_codec.sv
// channel   | handshake                        | payload
// ----------+----------------------------------+-------------------------------
// input     | in_valid / in_ready              | data_byte, end_of_message
// output    | out_valid / out_ready            | out_byte, last_of_run
// config    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// an input transfer is taken when in_valid and in_ready are both high; its results, up to four,
// leave one per cycle from the result register while out_ready is high
// the next input is accepted in the cycle the last held result leaves
// arst_n clears direction, the group state and the result valid flag and indices, not the result bytes
`default_nettype none

module base64_stream_codec (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             end_of_message,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [7:0]                            out_byte,
	output logic                                  last_of_run,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [b64sc_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import b64sc_pkg::*;

	logic    direction_q;
	logic    accept;
	result_t result;

	assign pready = 1'b1;
	assign accept = in_valid && in_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DIRECTION) begin
			direction_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	b64sc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.direction      (direction_q),
		.accept         (accept),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.result         (result)
	);

	b64sc_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.result      (result),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

>>> design/b64sc_core.sv
`default_nettype none

module b64sc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              direction,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              end_of_message,
	output b64sc_pkg::result_t     result
);
	import b64sc_pkg::*;

	logic [23:0] buf_q, buf_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        halt_q, halt_d;
	logic [23:0] shifted8, shifted6, grp_enc, grp_dec;
	logic [6:0]  sext;

	assign shifted8 = {buf_q[15:0], data_byte};
	assign sext     = char_to_sextet(data_byte);
	assign shifted6 = {buf_q[17:0], sext[5:0]};

	// next state and results of one transfer
	always_comb begin
		buf_d   = buf_q;
		cnt_d   = cnt_q;
		halt_d  = halt_q;
		result  = '0;
		grp_enc = '0;
		grp_dec = '0;
		if (direction == DIR_ENCODE) begin
			if (cnt_q >= 2'd2) begin
				result.any      = 1'b1;
				result.last_idx = 2'd3;
				result.bytes[0] = sextet_to_char(shifted8[23:18]);
				result.bytes[1] = sextet_to_char(shifted8[17:12]);
				result.bytes[2] = sextet_to_char(shifted8[11:6]);
				result.bytes[3] = sextet_to_char(shifted8[5:0]);
				buf_d = '0;
				cnt_d = '0;
			end else begin
				buf_d = shifted8;
				cnt_d = 2'(cnt_q + 2'd1);
				if (end_of_message) begin
					grp_enc = (cnt_q == 2'd0) ? {shifted8[7:0], 16'h0000}
						: {shifted8[15:0], 8'h00};
					result.any      = 1'b1;
					result.last_idx = 2'd3;
					result.bytes[0] = sextet_to_char(grp_enc[23:18]);
					result.bytes[1] = sextet_to_char(grp_enc[17:12]);
					result.bytes[2] = (cnt_q == 2'd0) ? PAD_CHAR
						: sextet_to_char(grp_enc[11:6]);
					result.bytes[3] = PAD_CHAR;
				end
			end
		end else begin
			if (halt_q || sext[6]) begin
				halt_d = 1'b1;
			end else if (cnt_q == 2'd3) begin
				result.any      = 1'b1;
				result.last_idx = 2'd2;
				result.bytes[0] = shifted6[23:16];
				result.bytes[1] = shifted6[15:8];
				result.bytes[2] = shifted6[7:0];
				buf_d = '0;
				cnt_d = '0;
			end else begin
				buf_d = shifted6;
				cnt_d = 2'(cnt_q + 2'd1);
			end
			// flush of a partial group of two or three sextets
			if (end_of_message && cnt_d >= 2'd2) begin
				grp_dec = (cnt_d == 2'd2) ? {buf_d[11:0], 12'h000}
					: {buf_d[17:0], 6'h00};
				result.any      = 1'b1;
				result.last_idx = (cnt_d == 2'd2) ? 2'd0 : 2'd1;
				result.bytes[0] = grp_dec[23:16];
				result.bytes[1] = grp_dec[15:8];
			end
		end
		if (end_of_message) begin
			buf_d  = '0;
			cnt_d  = '0;
			halt_d = 1'b0;
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= '0;
			halt_q <= 1'b0;
		end else if (accept) begin
			buf_q  <= buf_d;
			cnt_q  <= cnt_d;
			halt_q <= halt_d;
		end
	end

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_message |=> cnt_q == 2'd0 && !halt_q && buf_q == 24'd0)
		else $error("group state not cleared after last transfer");
	a_encode_flush_four: assert property (@(posedge clk) disable iff (!arst_n)
		accept && direction == DIR_ENCODE && end_of_message
		|-> result.any && result.last_idx == 2'd3)
		else $error("encode flush does not give four characters");
	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && halt_q && direction == DIR_DECODE && !end_of_message
		|=> halt_q && $stable(cnt_q))
		else $error("halted decode changed group state");
`endif

endmodule

`default_nettype wire

>>> design/b64sc_outq.sv
`default_nettype none

module b64sc_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire b64sc_pkg::result_t result,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   last_of_run
);
	import b64sc_pkg::*;

	logic            res_valid_q;
	logic [1:0]      idx_q;
	logic [1:0]      last_idx_q;
	logic [3:0][7:0] bytes_q;
	logic            drain_last;

	// the last byte of the held run leaves in this cycle
	assign drain_last  = res_valid_q && out_ready && (idx_q == last_idx_q);
	assign in_ready    = !res_valid_q || drain_last;
	assign out_valid   = res_valid_q;
	assign out_byte    = bytes_q[idx_q];
	assign last_of_run = (idx_q == last_idx_q);

	// run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q       <= '0;
			last_idx_q  <= '0;
		end else if (accept && result.any) begin
			res_valid_q <= 1'b1;
			idx_q       <= '0;
			last_idx_q  <= result.last_idx;
		end else if (res_valid_q && out_ready) begin
			if (idx_q == last_idx_q) begin
				res_valid_q <= 1'b0;
			end else begin
				idx_q <= 2'(idx_q + 2'd1);
			end
		end
	end

	// result bytes
	always_ff @(posedge clk) begin
		if (accept && result.any) begin
			bytes_q <= result.bytes;
		end
	end

`ifndef ASSERT_OFF
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> idx_q <= last_idx_q)
		else $error("result index past end of run");
	a_stall_holds_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_ready && !accept |=> res_valid_q && $stable(idx_q))
		else $error("stalled result moved");
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		drain_last && !(accept && result.any) |=> !res_valid_q)
		else $error("run not released after last transfer");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.any && res_valid_q |-> drain_last)
		else $error("held run overwritten");
`endif

endmodule

`default_nettype wire

>>> bench/base64_stream_codec_tb.sv
`default_nettype none

module base64_stream_codec_tb;

	import b64sc_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 150;
	localparam int MAX_REPORTS = 40;
	localparam logic [8*64-1:0] B64_CHARS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] data;
		logic       eom;
	} feed_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} out_word_t;

	// dut ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = 8'h00;
	logic                end_of_message = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          out_byte;
	logic                last_of_run;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = 32'h0;
	logic [31:0]         prdata;
	logic                pready;

	// stimulus and expectation stores
	feed_item_t byte_feed_q[$];
	out_word_t  b64_out_q[$];
	int         items_queued = 0;
	int         items_taken = 0;
	int         errors = 0;
	int         cycle_count = 0;
	bit         in_taken = 1'b0;
	bit         out_taken = 1'b0;
	bit         no_idle = 1'b0;
	bit         hold_req = 1'b0;
	int         in_gap = 0;
	int         out_wait = 0;
	int         hold_left = 0;

	// predictor state
	logic        model_dir = DIR_ENCODE;
	logic [23:0] model_buf = '0;
	logic [1:0]  model_cnt = '0;
	logic        model_halted = 1'b0;
	logic [6:0]  sextet_of[256];

	base64_stream_codec i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [7:0] enc_char(input logic [5:0] v);
		return B64_CHARS[8*(63-int'(v)) +: 8];
	endfunction

	// expected output bytes for one accepted input transfer
	function automatic void b64_predict_step(input logic [7:0] b, input logic eom);
		logic [7:0]  res[4];
		int          n;
		int          i;
		logic [1:0]  prior;
		logic [6:0]  s;
		logic [23:0] g;
		out_word_t   w;
		n = 0;
		if (model_dir == DIR_ENCODE) begin
			prior = model_cnt;
			model_buf = {model_buf[15:0], b};
			if (prior >= 2'd2) begin
				for (int k = 0; k < 4; k++) begin
					res[n] = enc_char(model_buf[18-6*k +: 6]);
					n++;
				end
				model_buf = '0;
				model_cnt = '0;
			end else begin
				model_cnt = prior + 2'd1;
				if (eom) begin
					i = int'(model_cnt);
					g = model_buf << (8 * (3 - i));
					for (int k = 0; k < 4; k++) begin
						res[n] = (k <= i) ? enc_char(g[18-6*k +: 6]) : PAD_CHAR;
						n++;
					end
				end
			end
		end else begin
			s = sextet_of[b];
			if (model_halted || s[6]) begin
				model_halted = 1'b1;
			end else begin
				model_buf = {model_buf[17:0], s[5:0]};
				if (model_cnt == 2'd3) begin
					for (int k = 0; k < 3; k++) begin
						res[n] = model_buf[16-8*k +: 8];
						n++;
					end
					model_buf = '0;
					model_cnt = '0;
				end else begin
					model_cnt = model_cnt + 2'd1;
				end
			end
			// partial group flush, a single sextet gives nothing
			if (eom && model_cnt >= 2'd2) begin
				i = int'(model_cnt);
				g = model_buf << (6 * (4 - i));
				for (int k = 0; k < i - 1; k++) begin
					res[n] = g[16-8*k +: 8];
					n++;
				end
			end
		end
		if (eom) begin
			model_buf = '0;
			model_cnt = '0;
			model_halted = 1'b0;
		end
		for (int k = 0; k < n; k++) begin
			w.value = res[k];
			w.last = (k == n - 1);
			b64_out_q.push_back(w);
		end
	endfunction

	// monitor: record accepted transfers, check results, watch the cycle limit
	always @(posedge clk) begin
		cycle_count++;
		in_taken = 1'b0;
		out_taken = 1'b0;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				out_taken = 1'b1;
				if (b64_out_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result out_byte %02h last_of_run %b",
							$time, out_byte, last_of_run);
				end else begin
					out_word_t want;
					want = b64_out_q.pop_front();
					if (want.value !== out_byte) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: out_byte expected %02h actual %02h",
								$time, want.value, out_byte);
					end
					if (want.last !== last_of_run) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: last_of_run expected %b actual %b",
								$time, want.last, last_of_run);
					end
				end
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				items_taken++;
				b64_predict_step(data_byte, end_of_message);
			end
		end
	end

	// input driver, one transfer per queued item with a random gap after it unless no_idle is set
	always @(negedge clk) begin
		feed_item_t nxt;
		if (!in_valid || in_taken) begin
			if (in_gap > 0 || byte_feed_q.size() == 0) begin
				if (in_gap > 0)
					in_gap--;
				in_valid <= 1'b0;
			end else begin
				nxt = byte_feed_q.pop_front();
				in_valid <= 1'b1;
				data_byte <= nxt.data;
				end_of_message <= nxt.eom;
				in_gap = no_idle ? 0 : $urandom_range(0, 10);
			end
		end
	end

	// result receiver with random stalls and an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (out_taken)
				out_wait = no_idle ? 0 : $urandom_range(0, 10);
			if (out_wait > 0) begin
				out_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic push_item(input logic [7:0] d, input logic eom);
		feed_item_t it;
		it.data = d;
		it.eom = eom;
		byte_feed_q.push_back(it);
		items_queued++;
	endtask

	task automatic push_text(input string s, input bit eom_end);
		for (int k = 0; k < s.len(); k++)
			push_item(s[k], eom_end && (k == s.len() - 1));
	endtask

	// wait until every item is taken and every result has arrived
	task automatic wait_idle();
		@(negedge clk);
		while (items_taken != items_queued || b64_out_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// register write: setup and access cycle, only while the block is idle
	task automatic set_direction(input logic dir);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_DIRECTION, 2'b00};
		pwdata <= {31'h0, dir};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		model_dir = dir;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_encode_message(input int len, input bit close);
		for (int k = 0; k < len; k++)
			push_item(8'($urandom_range(0, 255)), close && (k == len - 1));
	endtask

	// mostly well-formed base64 text, sometimes with a stray byte inside
	task automatic queue_decode_message(input int len, input bit close);
		logic [7:0] body[$];
		int         noise_at;
		int         pads;
		noise_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
		for (int k = 0; k < len; k++) begin
			if (k == noise_at)
				body.push_back(8'($urandom_range(0, 255)));
			else
				body.push_back(enc_char(6'($urandom_range(0, 63))));
		end
		pads = (close && (len % 4) >= 2) ? 4 - (len % 4) : 0;
		for (int k = 0; k < pads; k++)
			body.push_back(PAD_CHAR);
		for (int k = 0; k < body.size(); k++)
			push_item(body[k], close && (k == body.size() - 1));
	endtask

	// one random phase under a fixed direction
	task automatic run_phase(input logic dir, input int budget, input bit quiet,
		input bit squeeze);
		int left;
		int len;
		bit close;
		set_direction(dir);
		no_idle = quiet;
		left = budget;
		while (left > 0) begin
			len = $urandom_range(1, 10);
			if (len > left)
				len = left;
			// the final message may stay open across the next mode change
			close = (len < left) || ($urandom_range(0, 2) != 0);
			if (dir == DIR_ENCODE)
				queue_encode_message(len, close);
			else
				queue_decode_message(len, close);
			left -= len;
		end
		if (squeeze) begin
			@(posedge clk);
			hold_req = 1'b1;
		end
	endtask

	// sequence of phases
	initial begin
		for (int k = 0; k < 256; k++)
			sextet_of[k] = 7'd64;
		for (int k = 0; k < 64; k++)
			sextet_of[enc_char(6'(k))] = 7'(k);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// encode: padded flushes of one and two bytes, a full group, bit extremes
		set_direction(DIR_ENCODE);
		push_item(8'h00, 1'b1);
		push_item(8'hff, 1'b0);
		push_item(8'hff, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'hff, 1'b0);
		push_item(8'h80, 1'b1);

		// decode: padding stop, full group, single leftover sextet, stop on a high byte
		set_direction(DIR_DECODE);
		push_text("QQ==", 1'b1);
		push_text("//+9", 1'b1);
		push_text("A", 1'b1);
		push_text("Zm", 1'b0);
		push_item(8'hc8, 1'b0);
		push_text("x", 1'b1);

		// mode change with a partial group held
		set_direction(DIR_ENCODE);
		push_item(8'h78, 1'b0);
		push_item(8'h79, 1'b0);
		set_direction(DIR_DECODE);
		push_text("A", 1'b1);
		push_text("QUJ", 1'b0);
		set_direction(DIR_ENCODE);
		push_item(8'h41, 1'b1);

		// random phases alternating direction
		for (int p = 0; p < 8; p++)
			run_phase((p % 2 == 0) ? DIR_ENCODE : DIR_DECODE, 45, (p == 2 || p == 5),
				(p == 3));

		wait_idle();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

>>> base64_stream_codec.f
design/b64sc_pkg.sv
design/b64sc_core.sv
design/b64sc_outq.sv
design/base64_stream_codec.sv
bench/base64_stream_codec_tb.sv
